[hdl/assert_macros.svh]
// Assertion macros shared by the wrapping union-find RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define WUF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression never true outside reset.
`define WUF_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WUF_ASSERT(lbl, clk, rst_n, prop, msg)
`define WUF_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[hdl/wuf_pkg.sv]
// Shared types and constants for the wrapping union-find block.
// No dependencies; imported by every module of the block.
package wuf_pkg;

    localparam int SITE_W    = 10;
    localparam int STEP_W    = 3;
    localparam int OFS_W     = 12;
    localparam int DEF_SITES = 1024;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F1,
        ST_F2,
        ST_J1,
        ST_J2,
        ST_J3,
        ST_J4,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [OFS_W-1:0] x;
        logic [OFS_W-1:0] y;
    } t_ofs;

    typedef struct packed {
        logic sub;
        t_ofs a;
        t_ofs b;
    } t_alu_req;

endpackage

[hdl/wuf_alu.sv]
// Shared 2-lane offset adder/subtractor, modulo 2^OFS_W.
// Depends on wuf_pkg.
module wuf_alu
    import wuf_pkg::*;
(
    input  t_alu_req i_req,
    output t_ofs     o_sum
);

    always_comb begin
        if (i_req.sub) begin
            o_sum.x = i_req.a.x - i_req.b.x;
            o_sum.y = i_req.a.y - i_req.b.y;
        end else begin
            o_sum.x = i_req.a.x + i_req.b.x;
            o_sum.y = i_req.a.y + i_req.b.y;
        end
    end

endmodule

[hdl/wuf_mem.sv]
// Site table: parent, tree size, offset and wrap flag per site.
// One write port, one read port with registered data. Depends on wuf_pkg.
module wuf_mem
    import wuf_pkg::*;
#(
    parameter int SITES = DEF_SITES,
    localparam int IW = $clog2(SITES),
    localparam int SW = IW + 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [IW-1:0] i_wparent,
    input  logic [SW-1:0] i_wsize,
    input  t_ofs          i_wofs,
    input  logic          i_wwrap,
    input  logic [IW-1:0] i_raddr,
    output logic [IW-1:0] o_rparent,
    output logic [SW-1:0] o_rsize,
    output t_ofs          o_rofs,
    output logic          o_rwrap
);

    logic [IW-1:0] mem_parent [SITES];
    logic [SW-1:0] mem_size   [SITES];
    t_ofs          mem_ofs    [SITES];
    logic          mem_wrap   [SITES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_parent[i_waddr] <= i_wparent;
            mem_size[i_waddr]   <= i_wsize;
            mem_ofs[i_waddr]    <= i_wofs;
            mem_wrap[i_waddr]   <= i_wwrap;
        end
        o_rparent <= mem_parent[i_raddr];
        o_rsize   <= mem_size[i_raddr];
        o_rofs    <= mem_ofs[i_raddr];
        o_rwrap   <= mem_wrap[i_raddr];
    end

endmodule

[hdl/wrapping_union_find.sv]
// Wrapping union-find: disjoint-set table over lattice sites with torus wrap detection.
// Usage: one transaction on the input channel (i_in_valid / o_in_stall) carries an op.
//   clear: restores every site to its own root; no result.
//   add edge: finds both roots with path compression, then either flags a
//     nonzero closed loop or merges the smaller tree under the larger; no result.
//   query: finds the root of site_a and returns its wrap flag as one transaction
//     on the output channel (o_out_valid / i_out_stall).
// A locate walks the path twice, one node per cycle, through the
//   single read port of the site table.
//   Query: both walks for site_a, then ST_OUT. Edge: both walks for site_a and site_b,
//   then ST_J1 to ST_J3, and ST_J4 unless the roots match. Out-of-range edges and op 3
//   never leave ST_IDLE; an out-of-range query goes straight to ST_OUT.
// The block takes one item at a time; o_in_stall is high while it works.
// Reset (synchronous, active low) starts a clearing pass over the table, during
//   which the input is stalled.
// The result sits in an output register; while i_out_stall is high it holds,
//   and a following query waits in its last state until the register frees.
// Offsets are 12-bit two's complement and wrap modulo 4096.
// Depends on wuf_pkg, wuf_alu, wuf_mem and assert_macros.svh.
`include "assert_macros.svh"
module wrapping_union_find
    import wuf_pkg::*;
#(
    parameter int SITES = DEF_SITES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [SITE_W-1:0]        i_site_a,
    input  logic [SITE_W-1:0]        i_site_b,
    input  logic signed [STEP_W-1:0] i_step_x,
    input  logic signed [STEP_W-1:0] i_step_y,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_wraps
);

    localparam int IW = $clog2(SITES);
    localparam int SW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(SITES - 1);

    // control
    t_state        r_state, n_state;
    logic          r_side, n_side;        // 0: locating site_a, 1: site_b
    logic [IW-1:0] r_clr, n_clr;
    logic          r_out_valid, n_out_valid;

    // payload
    logic [1:0]               r_op;
    logic [SITE_W-1:0]        r_a, r_b;
    logic signed [STEP_W-1:0] r_sx, r_sy;
    logic [IW-1:0]            r_node, n_node;
    t_ofs                     r_acc, n_acc;   // running sum (walk 1) / rewrite value (walk 2)
    t_ofs                     r_dist, n_dist; // displacement of the located site to its root
    logic [IW-1:0]            r_root, n_root;
    logic [SW-1:0]            r_rsize, n_rsize;
    logic                     r_rwrap, n_rwrap;
    logic [IW-1:0]            r_ra, n_ra;     // site_a's root, saved across the second locate
    t_ofs                     r_da, n_da;
    logic [SW-1:0]            r_sa, n_sa;
    logic                     r_wa, n_wa;
    t_ofs                     r_j, n_j;       // loop / join displacement
    logic                     r_wraps, n_wraps;

    // table ports
    logic          c_we;
    logic [IW-1:0] c_waddr, c_wparent, c_raddr;
    logic [SW-1:0] c_wsize;
    t_ofs          c_wofs;
    logic          c_wwrap;
    logic [IW-1:0] m_parent;
    logic [SW-1:0] m_size;
    t_ofs          m_ofs;
    logic          m_wrap;

    // shared offset unit
    t_alu_req alu_req;
    t_ofs     alu_sum;

    logic acc_in;
    logic a_ok, b_ok;
    logic [IW-1:0] start_site;

    assign acc_in      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_wraps     = r_wraps;

    assign a_ok       = (32'(i_site_a) < 32'(SITES));
    assign b_ok       = (32'(i_site_b) < 32'(SITES));
    assign start_site = r_side ? IW'(r_b) : IW'(r_a);

    wuf_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    wuf_mem #(.SITES(SITES)) u_mem (
        .i_clk     (i_clk),
        .i_we      (c_we),
        .i_waddr   (c_waddr),
        .i_wparent (c_wparent),
        .i_wsize   (c_wsize),
        .i_wofs    (c_wofs),
        .i_wwrap   (c_wwrap),
        .i_raddr   (c_raddr),
        .o_rparent (m_parent),
        .o_rsize   (m_size),
        .o_rofs    (m_ofs),
        .o_rwrap   (m_wrap)
    );

    always_comb begin
        n_state     = r_state;
        n_side      = r_side;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_node      = r_node;
        n_acc       = r_acc;
        n_dist      = r_dist;
        n_root      = r_root;
        n_rsize     = r_rsize;
        n_rwrap     = r_rwrap;
        n_ra        = r_ra;
        n_da        = r_da;
        n_sa        = r_sa;
        n_wa        = r_wa;
        n_j         = r_j;
        n_wraps     = r_wraps;

        c_we      = 1'b0;
        c_waddr   = r_node;
        c_wparent = r_root;
        c_wsize   = m_size;
        c_wofs    = r_acc;
        c_wwrap   = m_wrap;
        c_raddr   = r_node;

        alu_req.sub = 1'b0;
        alu_req.a   = r_acc;
        alu_req.b   = m_ofs;

        unique case (r_state)
            ST_CLEAR: begin
                c_we      = 1'b1;
                c_waddr   = r_clr;
                c_wparent = r_clr;
                c_wsize   = SW'(1);
                c_wofs    = '0;
                c_wwrap   = 1'b0;
                n_clr     = r_clr + IW'(1);
                if (r_clr == LAST) begin
                    n_clr   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                c_raddr = IW'(i_site_a);
                if (acc_in) begin
                    n_side = 1'b0;
                    n_node = IW'(i_site_a);
                    n_acc  = '0;
                    case (i_op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_EDGE:  n_state = (a_ok && b_ok) ? ST_F1 : ST_IDLE;
                        OP_QUERY: begin
                            if (a_ok) begin
                                n_state = ST_F1;
                            end else begin
                                n_rwrap = 1'b0;
                                n_state = ST_OUT;
                            end
                        end
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_F1: begin
                // walk 1: sum offsets up to the root
                if (m_parent == r_node) begin
                    n_root  = r_node;
                    n_rsize = m_size;
                    n_rwrap = m_wrap;
                    n_dist  = r_acc;
                    n_node  = start_site;
                    c_raddr = start_site;
                    n_state = ST_F2;
                end else begin
                    n_acc   = alu_sum;
                    n_node  = m_parent;
                    c_raddr = m_parent;
                end
            end
            ST_F2: begin
                // walk 2: point each node at the root with its full displacement
                if (m_parent == r_node) begin
                    if (!r_side) begin
                        n_ra = r_root;
                        n_da = r_dist;
                        n_sa = r_rsize;
                        n_wa = r_rwrap;
                        if (r_op == OP_QUERY) begin
                            n_state = ST_OUT;
                        end else begin
                            n_side  = 1'b1;
                            n_node  = IW'(r_b);
                            c_raddr = IW'(r_b);
                            n_acc   = '0;
                            n_state = ST_F1;
                        end
                    end else begin
                        n_state = ST_J1;
                    end
                end else begin
                    c_we        = 1'b1;
                    alu_req.sub = 1'b1;
                    n_acc       = alu_sum;
                    n_node      = m_parent;
                    c_raddr     = m_parent;
                end
            end
            ST_J1: begin
                alu_req.a = r_da;
                alu_req.b.x = OFS_W'(r_sx);
                alu_req.b.y = OFS_W'(r_sy);
                n_j       = alu_sum;
                n_state   = ST_J2;
            end
            ST_J2: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_j;
                alu_req.b   = r_dist;
                n_j         = alu_sum;
                n_state     = ST_J3;
            end
            ST_J3: begin
                // root offsets are never summed, so roots are written with zero
                alu_req.sub = 1'b1;
                alu_req.a   = '0;
                alu_req.b   = r_j;
                priority if (r_ra == r_root) begin
                    c_we      = (r_j != '0);
                    c_waddr   = r_ra;
                    c_wparent = r_ra;
                    c_wsize   = r_sa;
                    c_wofs    = '0;
                    c_wwrap   = 1'b1;
                    n_state   = ST_IDLE;
                end else if (r_sa >= r_rsize) begin
                    c_we      = 1'b1;
                    c_waddr   = r_root;
                    c_wparent = r_ra;
                    c_wsize   = r_rsize;
                    c_wofs    = r_j;
                    c_wwrap   = r_rwrap;
                    n_node    = r_ra;
                    n_state   = ST_J4;
                end else begin
                    c_we      = 1'b1;
                    c_waddr   = r_ra;
                    c_wparent = r_root;
                    c_wsize   = r_sa;
                    c_wofs    = alu_sum;
                    c_wwrap   = r_wa;
                    n_node    = r_root;
                    n_state   = ST_J4;
                end
            end
            ST_J4: begin
                c_we      = 1'b1;
                c_waddr   = r_node;
                c_wparent = r_node;
                c_wsize   = SW'(r_sa + r_rsize);
                c_wofs    = '0;
                c_wwrap   = r_wa || r_rwrap;
                n_state   = ST_IDLE;
            end
            ST_OUT: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid = 1'b1;
                    n_wraps     = r_rwrap;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_side      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_side      <= n_side;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_op <= i_op;
            r_a  <= i_site_a;
            r_b  <= i_site_b;
            r_sx <= i_step_x;
            r_sy <= i_step_y;
        end
        r_node  <= n_node;
        r_acc   <= n_acc;
        r_dist  <= n_dist;
        r_root  <= n_root;
        r_rsize <= n_rsize;
        r_rwrap <= n_rwrap;
        r_ra    <= n_ra;
        r_da    <= n_da;
        r_sa    <= n_sa;
        r_wa    <= n_wa;
        r_j     <= n_j;
        r_wraps <= n_wraps;
    end

    // a result only appears from the result state
    `WUF_ASSERT(a_out_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_OUT), "result without query")
    // table writes never happen while idle
    `WUF_NEVER(a_no_idle_wr, i_clk, i_rst_n, c_we && (r_state == ST_IDLE), "table write while idle")
    // a clear transaction starts the sweep at entry zero
    `WUF_ASSERT(a_clr_start, i_clk, i_rst_n, (acc_in && (i_op == OP_CLEAR)) |=> ((r_state == ST_CLEAR) && (r_clr == '0)), "clear sweep not started")
    // the sweep counter only moves during a clear
    `WUF_NEVER(a_clr_idle, i_clk, i_rst_n, (r_state != ST_CLEAR) && (r_clr != '0), "sweep counter out of clear")

endmodule

[tb/wuf_checker.sv]
// Checker for the wrapping union-find block: watches both channels, keeps its own
// copy of the site table and compares every wraps result with the predicted one.
// Depends on wuf_pkg.
module wuf_checker
    import wuf_pkg::*;
#(
    parameter int SITES = DEF_SITES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [1:0]               i_op,
    input  logic [SITE_W-1:0]        i_site_a,
    input  logic [SITE_W-1:0]        i_site_b,
    input  logic signed [STEP_W-1:0] i_step_x,
    input  logic signed [STEP_W-1:0] i_step_y,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic                     i_wraps,
    output int                       o_fail_count,
    output int                       o_pending
);

    logic [SITE_W-1:0] parent_of    [SITES];
    logic [SITE_W:0]   tree_size_of [SITES];
    logic [OFS_W-1:0]  dx_to_parent [SITES];
    logic [OFS_W-1:0]  dy_to_parent [SITES];
    logic              wrap_of      [SITES];

    bit expected_wraps[$];
    int fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void reset_table();
        for (int k = 0; k < SITES; k++) begin
            parent_of[k]    = SITE_W'(k);
            tree_size_of[k] = (SITE_W+1)'(1);
            dx_to_parent[k] = '0;
            dy_to_parent[k] = '0;
            wrap_of[k]      = 1'b0;
        end
    endfunction

    function automatic logic [OFS_W-1:0] widen_step(input logic [STEP_W-1:0] s);
        return {{(OFS_W-STEP_W){s[STEP_W-1]}}, s};
    endfunction

    // Root of a site plus its displacement to the root; compresses the path.
    function automatic int find_root(input int site, output t_ofs disp);
        int   node;
        int   nxt;
        int   root;
        t_ofs acc;
        t_ofs rest;
        t_ofs hop;
        node = site;
        acc  = '0;
        for (int g = 0; g < SITES && int'(parent_of[node]) != node; g++) begin
            acc.x = acc.x + dx_to_parent[node];
            acc.y = acc.y + dy_to_parent[node];
            node  = int'(parent_of[node]);
        end
        root = node;
        node = site;
        rest = acc;
        for (int g = 0; g < SITES && int'(parent_of[node]) != node; g++) begin
            nxt   = int'(parent_of[node]);
            hop.x = dx_to_parent[node];
            hop.y = dy_to_parent[node];
            parent_of[node]    = SITE_W'(root);
            dx_to_parent[node] = rest.x;
            dy_to_parent[node] = rest.y;
            rest.x = rest.x - hop.x;
            rest.y = rest.y - hop.y;
            node   = nxt;
        end
        disp = acc;
        return root;
    endfunction

    function automatic void join_sites(input int a, input int b,
                                       input logic [STEP_W-1:0] sx,
                                       input logic [STEP_W-1:0] sy);
        int   ra;
        int   rb;
        t_ofs da;
        t_ofs db;
        t_ofs link;
        ra = find_root(a, da);
        rb = find_root(b, db);
        link.x = da.x + widen_step(sx) - db.x;
        link.y = da.y + widen_step(sy) - db.y;
        if (ra == rb) begin
            // closed loop with nonzero displacement wraps the torus
            if (link != '0) wrap_of[ra] = 1'b1;
        end else if (tree_size_of[ra] >= tree_size_of[rb]) begin
            parent_of[rb]    = SITE_W'(ra);
            dx_to_parent[rb] = link.x;
            dy_to_parent[rb] = link.y;
            tree_size_of[ra] = tree_size_of[ra] + tree_size_of[rb];
            wrap_of[ra]      = wrap_of[ra] | wrap_of[rb];
        end else begin
            parent_of[ra]    = SITE_W'(rb);
            dx_to_parent[ra] = -link.x;
            dy_to_parent[ra] = -link.y;
            tree_size_of[rb] = tree_size_of[rb] + tree_size_of[ra];
            wrap_of[rb]      = wrap_of[ra] | wrap_of[rb];
        end
    endfunction

    always @(posedge i_clk) begin
        int   root;
        t_ofs disp;
        bit   want;
        if (!i_rst_n) begin
            reset_table();
            expected_wraps.delete();
        end else begin
            // result side first: a result never belongs to a query taken in the same cycle
            if (i_out_valid && !i_out_stall) begin
                if (expected_wraps.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual wraps=%b",
                             $time, i_wraps);
                end else begin
                    want = expected_wraps.pop_front();
                    if (i_wraps !== want) begin
                        fail_count++;
                        $display("%0t: wraps mismatch, expected %b, actual %b",
                                 $time, want, i_wraps);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_op)
                    OP_CLEAR: reset_table();
                    OP_EDGE: begin
                        if (int'(i_site_a) < SITES && int'(i_site_b) < SITES)
                            join_sites(int'(i_site_a), int'(i_site_b), i_step_x, i_step_y);
                    end
                    OP_QUERY: begin
                        if (int'(i_site_a) >= SITES) begin
                            expected_wraps.insert(expected_wraps.size(), 1'b0);
                        end else begin
                            root = find_root(int'(i_site_a), disp);
                            expected_wraps.insert(expected_wraps.size(), bit'(wrap_of[root]));
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= expected_wraps.size();
    end

endmodule

[tb/tb_wrapping_union_find.sv]
// Testbench top for wrapping_union_find: drives directed and random transactions,
// toggles idling on both channels and reports the verdict from wuf_checker.
// Depends on wuf_pkg, wuf_checker and the block's RTL.
module tb_wrapping_union_find;
    import wuf_pkg::*;

    localparam int          SITES_N      = DEF_SITES;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;   // ignored by the block
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          STALL_LIMIT  = 20000;  // quiet cycles before giving up
    localparam int          DRAIN_CYCLES = 100;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_op       = OP_CLEAR;
    logic [SITE_W-1:0]        i_site_a   = '0;
    logic [SITE_W-1:0]        i_site_b   = '0;
    logic signed [STEP_W-1:0] i_step_x   = '0;
    logic signed [STEP_W-1:0] i_step_y   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_wraps;

    int fail_count;
    int pending;

    // idle rates in percent, changed per phase
    int send_idle_pct = 13;
    int recv_idle_pct = 65;
    int sent_count    = 0;
    int quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    wrapping_union_find #(.SITES(SITES_N)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_site_a    (i_site_a),
        .i_site_b    (i_site_b),
        .i_step_x    (i_step_x),
        .i_step_y    (i_step_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_wraps     (o_wraps)
    );

    wuf_checker #(.SITES(SITES_N)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_site_a     (i_site_a),
        .i_site_b     (i_site_b),
        .i_step_x     (i_step_x),
        .i_step_y     (i_step_y),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_wraps      (o_wraps),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver back-pressure: fresh random stall every cycle at the phase's rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: any cycle with no transaction on either channel counts toward the limit.
    // Clears and the post-reset clearing pass end well under it.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One input transaction. Optional idle cycles go first so that valid is only
    // ever assigned once per edge; valid stays high into the next item otherwise.
    task automatic send_item(input logic [1:0] op, input int a, input int b,
                             input int sx, input int sy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_site_a   <= a[SITE_W-1:0];
        i_site_b   <= b[SITE_W-1:0];
        i_step_x   <= sx[STEP_W-1:0];
        i_step_y   <= sy[STEP_W-1:0];
        @(posedge i_clk);
        // values read here are the ones sampled at this edge
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic int rand_step();
        return $urandom_range(4) - 2;
    endfunction

    // Directed: empty table, consistent and inconsistent loops, self edges,
    // size tie, merging a wrapping tree, the ignored op, clear then query.
    task automatic run_directed();
        send_item(OP_CLEAR, 1023, 1023, -2, 2);
        send_item(OP_QUERY, 0, 0, 0, 0);
        send_item(OP_QUERY, 1023, 0, 0, 0);
        send_item(OP_EDGE, 0, 1, 1, 0);
        send_item(OP_EDGE, 1, 0, -1, 0);          // closes with zero sum: no wrap
        send_item(OP_QUERY, 0, 0, 0, 0);
        send_item(OP_EDGE, 0, 1, 2, -2);          // disagreeing loop: wraps
        send_item(OP_QUERY, 1, 0, 0, 0);
        send_item(OP_EDGE, 5, 5, 0, 0);           // self edge, zero step
        send_item(OP_QUERY, 5, 0, 0, 0);
        send_item(OP_EDGE, 5, 5, -2, 2);          // self edge, nonzero step
        send_item(OP_QUERY, 5, 0, 0, 0);
        send_item(OP_EDGE, 1023, 1022, -1, 0);    // equal sizes: b under a
        send_item(OP_EDGE, 1022, 512, 0, 1);
        send_item(OP_EDGE, 7, 0, 1, 1);           // joins onto the wrapping tree
        send_item(OP_QUERY, 7, 0, 0, 0);
        send_item(OP_QUERY, 512, 0, 0, 0);
        send_item(OP_UNUSED, 3, 4, 1, -1);
        send_item(OP_EDGE, 512, 1023, 1, -1);     // 512 -> 1022 -> 1023 adds to zero
        send_item(OP_QUERY, 1023, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0);
        send_item(OP_QUERY, 1, 0, 0, 0);
    endtask

    // One episode on a small torus placed somewhere in the table: mostly
    // geometric edges with true displacements, queries in between, some noise.
    task automatic run_lattice(input int n_items);
        int w;
        int h;
        int base;
        int x;
        int y;
        int dx;
        int dy;
        int pick;
        if ($urandom_range(7) == 0) begin
            w = $urandom_range(32, 8);
            h = $urandom_range(32, 8);
        end else begin
            w = $urandom_range(8, 2);
            h = $urandom_range(8, 2);
        end
        base = $urandom_range(SITES_N - w * h);
        if ($urandom_range(9) < 8)
            send_item(OP_CLEAR, $urandom_range(1023), $urandom_range(1023),
                      rand_step(), rand_step());
        repeat (n_items) begin
            pick = $urandom_range(99);
            x    = $urandom_range(w - 1);
            y    = $urandom_range(h - 1);
            dx   = rand_step();
            dy   = rand_step();
            if (pick < 55)
                send_item(OP_EDGE, base + y * w + x,
                          base + ((y + dy + h) % h) * w + (x + dx + w) % w, dx, dy);
            else if (pick < 88)
                send_item(OP_QUERY, base + y * w + x, $urandom_range(1023), dx, dy);
            else if (pick < 94)
                send_item(OP_EDGE, $urandom_range(1023), $urandom_range(1023), dx, dy);
            else if (pick < 99)
                send_item(OP_QUERY, $urandom_range(1023), $urandom_range(1023), dx, dy);
            else
                send_item(OP_UNUSED, $urandom_range(1023), $urandom_range(1023), dx, dy);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        sent_count = 0;
        // phase 1: sender idles lightly, receiver heavily
        while (sent_count < RANDOM_ITEMS / 3)
            run_lattice($urandom_range(90, 30));
        // phase 2: the other way round
        send_idle_pct = 65;
        recv_idle_pct = 13;
        while (sent_count < 2 * RANDOM_ITEMS / 3)
            run_lattice($urandom_range(90, 30));
        // phase 3: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_count < RANDOM_ITEMS)
            run_lattice($urandom_range(90, 30));

        i_in_valid <= 1'b0;
        // pending is registered; the watchdog covers a result that never comes
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
